### design/frcl_pkg.sv
// Shared types and constants for the FIFO-replacement cache lookup unit.
package frcl_pkg;

  localparam int unsigned KEY_W        = 32;
  localparam int unsigned CNT_W        = 48;
  localparam int unsigned CAPACITY_DEF = 64;

  // Result transaction layout, from the lowest bit up.
  localparam int unsigned OUT_HIT_LSB   = 0;
  localparam int unsigned OUT_CNTD_LSB  = 1;
  localparam int unsigned OUT_EVV_LSB   = 2;
  localparam int unsigned OUT_EVK_LSB   = 3;
  localparam int unsigned OUT_TOT_LSB   = OUT_EVK_LSB + KEY_W;
  localparam int unsigned OUT_MISS_LSB  = OUT_TOT_LSB + CNT_W;
  localparam int unsigned OUT_USED_W    = OUT_MISS_LSB + CNT_W;
  localparam int unsigned OUT_W         = ((OUT_USED_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W     = OUT_W - OUT_USED_W;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_DONE
  } state_e;

  // Lookup token that walks down the cell row.
  typedef struct packed {
    logic             vld;
    logic             hit;
    logic [KEY_W-1:0] key;
  } probe_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
  endfunction

endpackage

### design/fifo_replacement_cache_lookup_unit.sv
// Top level of the FIFO-replacement fully associative cache lookup unit.
// Each input transaction carries one 32-bit block key. The keys live in a row
// of CAPACITY cells ordered from newest (cell 0) to oldest (last cell). A
// lookup launches a probe into cell 0 that advances one cell per cycle,
// comparing against every occupied cell on its way; when it leaves the last
// cell the hit flag is final. On a miss the whole row shifts by one cell at
// once: the new key enters cell 0 and, when the row is full, the key
// leaving the last cell is the evicted (oldest) one. The first eviction sets
// the warm flag; from then on the 48-bit total and miss counters advance,
// saturating at all ones. One item is handled at a time: the probe crosses
// the cell row, the result is committed once the output register is free,
// and the unit returns to idle before it accepts the next key.
// The result sits in an output register, so the next key is accepted while a
// result still waits to be taken. No clearing pass is needed after reset.
module fifo_replacement_cache_lookup_unit
  import frcl_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [KEY_W-1:0] s_axis_tdata_i,  // [31:0] block_key
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // [0] hit, [1] counted, [2] evicted_valid, [34:3] evicted_key,
  // [82:35] total_count, [130:83] miss_count, [135:131] zero
  output logic [OUT_W-1:0] m_axis_tdata_o
);

  localparam int unsigned OCC_W = $clog2(CAPACITY + 1);
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(CAPACITY);

  state_e state_q, state_d;

  logic [OCC_W-1:0] occ_q, occ_d;
  logic             warm_q, warm_d;
  logic [CNT_W-1:0] tot_q, tot_d;
  logic [CNT_W-1:0] miss_q, miss_d;
  logic             hit_q;
  logic [KEY_W-1:0] ins_key_q;

  logic             out_vld_q;
  logic [OUT_W-1:0] out_data_q;

  logic accept, commit, out_free, miss, full, evict, launch;

  // Cell row wiring: index 0 is the head, index CAPACITY the tail.
  probe_t           probe_w [CAPACITY+1];
  logic [OCC_W-1:0] rem_w   [CAPACITY+1];
  logic [KEY_W-1:0] key_w   [CAPACITY+1];

  assign probe_w[0] = '{vld: launch, hit: 1'b0, key: s_axis_tdata_i};
  assign rem_w[0]   = occ_q;
  assign key_w[0]   = ins_key_q;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    frcl_cell #(
      .REM_W(OCC_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .probe_i (probe_w[i]),
      .rem_i   (rem_w[i]),
      .probe_o (probe_w[i+1]),
      .rem_o   (rem_w[i+1]),
      .shift_i (commit & miss),
      .key_i   (key_w[i]),
      .key_o   (key_w[i+1])
    );
  end

  assign accept   = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free = ~out_vld_q | m_axis_tready_i;
  assign miss     = ~hit_q;
  assign full     = (occ_q == OCC_FULL);
  assign evict    = miss & full;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept) state_d = ST_PROBE;
      ST_PROBE: if (probe_w[CAPACITY].vld) state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    s_axis_tready_o = 1'b0;
    launch          = 1'b0;
    commit          = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        launch          = s_axis_tvalid_i;
      end
      ST_PROBE: ;
      ST_DONE:  commit = out_free;
      default: ;
    endcase
  end

  // Cache bookkeeping applied at commit.
  always_comb begin
    occ_d  = occ_q;
    warm_d = warm_q;
    tot_d  = tot_q;
    miss_d = miss_q;
    if (commit) begin
      if (miss && !full) begin
        occ_d = occ_q + OCC_W'(1);
      end
      warm_d = warm_q | evict;
      if (warm_d) begin
        tot_d = sat_inc(tot_q);
        if (miss) begin
          miss_d = sat_inc(miss_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      occ_q     <= '0;
      warm_q    <= 1'b0;
      tot_q     <= '0;
      miss_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      warm_q  <= warm_d;
      tot_q   <= tot_d;
      miss_q  <= miss_d;
      if (commit) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Latch the final probe and the result payload.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_PROBE && probe_w[CAPACITY].vld) begin
      hit_q     <= probe_w[CAPACITY].hit;
      ins_key_q <= probe_w[CAPACITY].key;
    end
    if (commit) begin
      out_data_q <= {{OUT_PAD_W{1'b0}}, miss_d, tot_d,
                     evict ? key_w[CAPACITY] : {KEY_W{1'b0}},
                     evict, warm_d, hit_q};
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

### design/frcl_cell.sv
// One storage cell of the key row: holds one key, compares the passing probe, shifts on insert.
module frcl_cell
  import frcl_pkg::*;
#(
  parameter int unsigned REM_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  probe_t           probe_i,
  input  logic [REM_W-1:0] rem_i,
  output probe_t           probe_o,
  output logic [REM_W-1:0] rem_o,
  input  logic             shift_i,
  input  logic [KEY_W-1:0] key_i,
  output logic [KEY_W-1:0] key_o
);

  logic [KEY_W-1:0] key_q;
  logic             vld_q;
  logic             hit_q, hit_d;
  logic [KEY_W-1:0] pkey_q;
  logic [REM_W-1:0] rem_q, rem_d;
  logic             occupied;

  // A probe only compares against cells still inside the occupied run.
  assign occupied = (rem_i != '0);
  assign hit_d    = probe_i.hit | (probe_i.vld & occupied & (probe_i.key == key_q));
  assign rem_d    = occupied ? rem_i - REM_W'(1) : rem_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= probe_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q  <= hit_d;
    pkey_q <= probe_i.key;
    rem_q  <= rem_d;
    if (shift_i) begin
      key_q <= key_i;
    end
  end

  assign probe_o = '{vld: vld_q, hit: hit_q, key: pkey_q};
  assign rem_o   = rem_q;
  assign key_o   = key_q;

endmodule

### design/frcl_checker.sv
// Port-level checker for the FIFO-replacement cache lookup unit, with its bind.
module frcl_port_checker
  import frcl_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid_i,
  input logic             s_axis_tready_o,
  input logic             m_axis_tvalid_o,
  input logic             m_axis_tready_i,
  input logic [OUT_W-1:0] m_axis_tdata_o
);

  logic counted_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counted_seen_q <= 1'b0;
    end else if (m_axis_tvalid_o && m_axis_tdata_o[OUT_CNTD_LSB]) begin
      counted_seen_q <= 1'b1;
    end
  end

  // One item in flight: a taken key closes the input until its lookup is done.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted while a lookup is in progress");

  // Warm-up never clears once reached.
  a_warm_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && counted_seen_q |-> m_axis_tdata_o[OUT_CNTD_LSB])
    else $error("counted flag dropped after warm-up");

  // Only a miss can evict, and no eviction means a zero evicted key.
  a_evict_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (!(m_axis_tdata_o[OUT_HIT_LSB] && m_axis_tdata_o[OUT_EVV_LSB]) &&
      (m_axis_tdata_o[OUT_EVV_LSB] ||
       m_axis_tdata_o[OUT_EVK_LSB +: KEY_W] == '0)))
    else $error("eviction fields inconsistent with hit");

  // Misses never outnumber counted accesses.
  a_miss_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      m_axis_tdata_o[OUT_MISS_LSB +: CNT_W] <= m_axis_tdata_o[OUT_TOT_LSB +: CNT_W])
    else $error("miss count exceeds total count");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result transaction changed");

endmodule

bind fifo_replacement_cache_lookup_unit frcl_port_checker u_frcl_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

### tb/frcl_checker.sv
// Predicts every lookup of the FIFO-replacement cache unit and compares each result.
module frcl_checker
  import frcl_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             key_valid_i,
  input  logic             key_ready_i,
  input  logic [KEY_W-1:0] key_data_i,
  input  logic             res_valid_i,
  input  logic             res_ready_i,
  input  logic [OUT_W-1:0] res_data_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o,
  output int unsigned      lookup_count_o,
  output int unsigned      hit_count_o,
  output int unsigned      evict_count_o
);

  typedef struct packed {
    logic             hit;
    logic             counted;
    logic             ev_valid;
    logic [KEY_W-1:0] ev_key;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] misses;
  } lookup_result_t;

  // Resident keys, oldest at the front.
  logic [KEY_W-1:0] resident_keys[$];
  logic             warm_q;
  logic [CNT_W-1:0] total_q;
  logic [CNT_W-1:0] miss_q;
  lookup_result_t   due_results[$];
  lookup_result_t   want;
  lookup_result_t   got;
  lookup_result_t   next_res;
  int unsigned      result_seen;

  function automatic lookup_result_t fifo_cache_access(input logic [KEY_W-1:0] key);
    lookup_result_t r;
    r = '0;
    foreach (resident_keys[i]) begin
      if (resident_keys[i] == key) r.hit = 1'b1;
    end
    if (!r.hit) begin
      if (resident_keys.size() >= CAPACITY) begin
        r.ev_valid = 1'b1;
        r.ev_key   = resident_keys.pop_front();
        warm_q     = 1'b1;
      end
      resident_keys.push_back(key);
    end
    if (warm_q) begin
      if (total_q != CNT_MAX) total_q = total_q + 1'b1;
      if (!r.hit && miss_q != CNT_MAX) miss_q = miss_q + 1'b1;
    end
    r.counted = warm_q;
    r.total   = total_q;
    r.misses  = miss_q;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] seen,
                                 input logic [63:0] wanted);
    $display("[%0t] result %0d, %s: got %0h, expected %0h",
             $time, result_seen, field, seen, wanted);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resident_keys.delete();
      due_results.delete();
      warm_q         = 1'b0;
      total_q        = '0;
      miss_q         = '0;
      result_seen    = 0;
      fail_count_o   = 0;
      pending_o      = 0;
      lookup_count_o = 0;
      hit_count_o    = 0;
      evict_count_o  = 0;
    end else begin
      // Compare the result transaction before taking the key of the same edge.
      if (res_valid_i && res_ready_i) begin
        result_seen++;
        if (due_results.size() == 0) begin
          report_mismatch("result with no lookup pending", res_data_i[63:0], '0);
        end else begin
          want       = due_results.pop_front();
          got.hit      = res_data_i[OUT_HIT_LSB];
          got.counted  = res_data_i[OUT_CNTD_LSB];
          got.ev_valid = res_data_i[OUT_EVV_LSB];
          got.ev_key   = res_data_i[OUT_EVK_LSB +: KEY_W];
          got.total    = res_data_i[OUT_TOT_LSB +: CNT_W];
          got.misses   = res_data_i[OUT_MISS_LSB +: CNT_W];
          if (got.hit !== want.hit) report_mismatch("hit", got.hit, want.hit);
          if (got.counted !== want.counted)
            report_mismatch("counted", got.counted, want.counted);
          if (got.ev_valid !== want.ev_valid)
            report_mismatch("evicted_valid", got.ev_valid, want.ev_valid);
          if (got.ev_key !== want.ev_key)
            report_mismatch("evicted_key", got.ev_key, want.ev_key);
          if (got.total !== want.total)
            report_mismatch("total_count", got.total, want.total);
          if (got.misses !== want.misses)
            report_mismatch("miss_count", got.misses, want.misses);
          if (res_data_i[OUT_W-1:OUT_USED_W] !== '0)
            report_mismatch("padding", res_data_i[OUT_W-1:OUT_USED_W], '0);
        end
      end
      if (key_valid_i && key_ready_i) begin
        next_res = fifo_cache_access(key_data_i);
        due_results.push_back(next_res);
        lookup_count_o++;
        if (next_res.hit) hit_count_o++;
        if (next_res.ev_valid) evict_count_o++;
      end
      pending_o = due_results.size();
    end
  end

endmodule

### tb/tb.sv
// Testbench top: drives key and result channels of the cache lookup unit and gives the verdict.
module tb
  import frcl_pkg::*;
;

  localparam int unsigned CAPACITY     = CAPACITY_DEF;
  localparam int unsigned RANDOM_ITEMS = 650;
  localparam int unsigned IDLE_PCT     = 21;
  localparam int unsigned POOL_SIZE    = 96;
  localparam int unsigned HOT_KEYS     = 12;
  // Slowest run is roughly 670 items, each crossing the cell row, plus gaps
  // and stalls; the limit leaves a wide margin over that.
  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int unsigned EDGE_COUNT   = 16;

  // Boundary keys, with repeats so that early hits are seen before the store fills.
  localparam logic [KEY_W-1:0] EDGE_KEYS [EDGE_COUNT] = '{
    32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
    32'h7FFF_FFFF, 32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA,
    32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFE, 32'h7FFF_FFFF,
    32'h8000_0001, 32'h0000_0001, 32'h5555_5555, 32'h0000_0000
  };

  logic             clk;
  logic             rst_n;
  logic             s_tvalid;
  logic             s_tready;
  logic [KEY_W-1:0] s_tdata;
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;
  logic             steady;

  int unsigned      fail_count;
  int unsigned      pending;
  int unsigned      lookup_count;
  int unsigned      hit_count;
  int unsigned      evict_count;
  int unsigned      cycle_count;

  fifo_replacement_cache_lookup_unit #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  frcl_checker #(
    .CAPACITY(CAPACITY)
  ) u_lookup_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .key_valid_i   (s_tvalid),
    .key_ready_i   (s_tready),
    .key_data_i    (s_tdata),
    .res_valid_i   (m_tvalid),
    .res_ready_i   (m_tready),
    .res_data_i    (m_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .lookup_count_o(lookup_count),
    .hit_count_o   (hit_count),
    .evict_count_o (evict_count)
  );

  // Free-running clock, period 20.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hold reset low from time zero, then release it at a falling edge.
  initial begin
    rst_n = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
  end

  // Result side: stall at random, except during the steady stretch.
  always @(negedge clk) begin
    if (!rst_n) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Watchdog: end the run with a failure if it never drains.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results still pending", cycle_count, pending);
    $display("Some tests failed");
    $finish;
  end

  // Offer one key transaction; called and returning at a falling edge.
  // Insert a random idle gap first, unless the steady stretch is on.
  task automatic send_key(input logic [KEY_W-1:0] key);
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      s_tdata  <= $urandom;
      do @(negedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= key;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  initial begin
    logic [KEY_W-1:0] pool [POOL_SIZE];
    logic [KEY_W-1:0] key;
    int unsigned      roll;

    // Hold the key side at a known value from time zero.
    s_tvalid = 1'b0;
    s_tdata  = '0;
    steady   = 1'b0;
    foreach (pool[i]) pool[i] = $urandom;
    @(negedge clk);
    while (!rst_n) @(negedge clk);

    // Directed part: boundary keys, cold misses and early hits.
    for (int i = 0; i < EDGE_COUNT; i++) send_key(EDGE_KEYS[i]);

    // Random part: a working set somewhat larger than the store gives a mix
    // of hits and evictions; hot keys raise the hit rate, fresh keys force misses.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 200 && n < 330);
      if (n == 480) begin
        // Hold off until every outstanding result has drained.
        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < 5) pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
      if (roll < 55) begin
        key = pool[$urandom_range(0, POOL_SIZE - 1)];
      end else if (roll < 78) begin
        key = pool[$urandom_range(0, HOT_KEYS - 1)];
      end else if (roll < 83) begin
        key = EDGE_KEYS[$urandom_range(0, EDGE_COUNT - 1)];
      end else begin
        key = $urandom;
      end
      send_key(key);
    end
    steady = 1'b0;
    s_tvalid <= 1'b0;

    // Drain, then give the unit time to show any stray result.
    while (pending != 0) @(negedge clk);
    repeat (CAPACITY + 8) @(negedge clk);

    $display("Ran %0d lookups (%0d boundary keys first): %0d hits, %0d evictions.",
             lookup_count, EDGE_COUNT, hit_count, evict_count);
    $display("Covered cold fill, FIFO eviction, warm-up counting and stalls on both sides.");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
